// ===== design/kmpd_pkg.sv =====
// shared types and constants of the keypad matrix press detector
package kmpd_pkg;

  localparam int NUM_ROWS   = 3;
  localparam int NUM_COLS   = 5;
  localparam int LEVEL_W    = 15;
  localparam int KEY_TOTAL  = (NUM_ROWS * NUM_COLS > LEVEL_W) ? LEVEL_W : NUM_ROWS * NUM_COLS;
  localparam int KEY_W      = 4;
  localparam int CODE_W     = 7;
  localparam int TABLE_W    = 56;
  localparam int INTERVAL_W = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LEVEL_W-1:0] KEY_MASK = LEVEL_W'((1 << KEY_TOTAL) - 1);
  localparam logic [KEY_W-1:0]   KEY_LAST = KEY_W'(KEY_TOTAL - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 2'd2;

  localparam logic [INTERVAL_W-1:0] DEBOUNCE_RESET = 16'd20;

  typedef struct packed {
    logic [LEVEL_W-1:0] key_levels;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [KEY_W-1:0]  key_number;
    logic              final_press;
  } out_item_t;

  // result handed from the scanner to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_FLUSH
  } scan_state_t;

endpackage

// ===== design/kmpd_scan.sv =====
// key-serial scanner: one key per cycle while no stalled output holds it, debounce timing and pending press
module kmpd_scan
  import kmpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  in_item_t                snap,
  input  logic [LEVEL_W-1:0]      prev_levels,
  input  logic [INTERVAL_W-1:0]   debounce_interval,
  input  logic [2*TABLE_W-1:0]    code_table,
  input  logic                    slot_free,
  output logic                    busy,
  output res_push_t               push
);

  scan_state_t             state, state_next;
  logic [KEY_W-1:0]        cnt;
  logic [LEVEL_W-1:0]      cur_sr;
  logic [LEVEL_W-1:0]      prev_sr;
  logic [2*TABLE_W-1:0]    code_sr;
  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       nat;
  logic                    pend_valid;
  logic [CODE_W-1:0]       pend_code;
  logic [KEY_W-1:0]        pend_num;
  logic                    hit;
  logic                    step;

  // press test on the key at the head of the shift registers
  assign hit  = (state == SCAN_RUN) && !cur_sr[0] && prev_sr[0] && (now >= nat);
  assign busy = (state != SCAN_IDLE);

  // sequencer and result push
  always_comb begin
    state_next      = state;
    step            = 1'b0;
    push.valid      = 1'b0;
    push.item.key_code    = pend_code;
    push.item.key_number  = pend_num;
    push.item.final_press = 1'b0;
    unique case (state)
      SCAN_IDLE: begin
        if (start) state_next = SCAN_RUN;
      end
      SCAN_RUN: begin
        // a new press pushes out the older pending one, which is then not the last
        step       = !(hit && pend_valid && !slot_free);
        push.valid = hit && pend_valid && slot_free;
        if (step && cnt == KEY_LAST) state_next = SCAN_FLUSH;
      end
      SCAN_FLUSH: begin
        push.valid            = pend_valid && slot_free;
        push.item.final_press = 1'b1;
        if (!pend_valid || slot_free) state_next = SCAN_IDLE;
      end
      default: state_next = SCAN_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SCAN_IDLE;
      nat        <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step && hit) begin
        nat        <= nat + TIME_W'(debounce_interval);
        pend_valid <= 1'b1;
      end else if (state == SCAN_FLUSH && state_next == SCAN_IDLE) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // shift registers and pending payload
  always_ff @(posedge clk) begin
    if (state == SCAN_IDLE && start) begin
      cnt     <= '0;
      cur_sr  <= snap.key_levels;
      prev_sr <= prev_levels;
      code_sr <= code_table;
      now     <= snap.now_ms;
    end else if (step) begin
      cnt     <= cnt + KEY_W'(1);
      cur_sr  <= cur_sr >> 1;
      prev_sr <= prev_sr >> 1;
      code_sr <= code_sr >> CODE_W;
    end
    if (step && hit) begin
      pend_code <= code_sr[CODE_W-1:0];
      pend_num  <= cnt;
    end
  end

endmodule

// ===== design/kmpd_outreg.sv =====
// output register holding one result until its transfer
module kmpd_outreg
  import kmpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  res_push_t push,
  output logic      slot_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  assign slot_free = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push.valid) out_data <= push.item;
  end

endmodule

// ===== design/keypad_matrix_press_detector.sv =====
// top level of the keypad matrix press detector
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+-------------------------
//  input   | in_valid, in_stall, in_data   | in_valid && !in_stall
//  output  | out_valid, out_stall, out_data| out_valid && !out_stall
//  config  | cfg_we, cfg_index, cfg_data   | cfg_we
//
// a snapshot is loaded at its transfer edge, then takes one cycle per key (15 keys)
// in the key-serial scanner when the output is never stalled, then passes the flush
// state and the idle state before the next transfer.
// the scanner walks the keys one at a time with a single 32-bit compare and add.
// in_stall is high while a snapshot is being scanned or flushed.
// a stalled output holds the scan whenever the pending press needs the output slot:
// at a second press of the snapshot, or in the flush cycle.
// synchronous reset clears timing state, previous levels and the code tables, and sets the debounce interval to 20.
module keypad_matrix_press_detector
  import kmpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TABLE_W-1:0]   cfg_data
);

  logic [INTERVAL_W-1:0] debounce_interval;
  logic [TABLE_W-1:0]    code_table_low;
  logic [TABLE_W-1:0]    code_table_high;
  logic [LEVEL_W-1:0]    previous_levels;
  logic                  busy;
  logic                  accept;
  logic                  slot_free;
  res_push_t             push;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_interval <= DEBOUNCE_RESET;
      code_table_low    <= '0;
      code_table_high   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_interval <= cfg_data[INTERVAL_W-1:0];
        CFG_TABLE_LOW:  code_table_low    <= cfg_data;
        CFG_TABLE_HIGH: code_table_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stored levels of the visited keys
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
    end else if (accept) begin
      previous_levels <= (in_data.key_levels & KEY_MASK) | (previous_levels & ~KEY_MASK);
    end
  end

  kmpd_scan u_scan (
    .clk               (clk),
    .rst               (rst),
    .start             (accept),
    .snap              (in_data),
    .prev_levels       (previous_levels),
    .debounce_interval (debounce_interval),
    .code_table        ({code_table_high, code_table_low}),
    .slot_free         (slot_free),
    .busy              (busy),
    .push              (push)
  );

  kmpd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the keypad matrix press detector
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kmpd_pkg::*;

  // index that maps to no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // hold after the last press so a scan with no press can finish
  localparam int SCAN_HOLD = 24;
  // watchdog limit on the run
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 110;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_SINGLE
  } row_check_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic [TIME_W-1:0]  now;
    row_check_e         chk;
    out_item_t          single;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [TABLE_W-1:0]   cfg_data = '0;

  // predictor state and configuration
  logic [INTERVAL_W-1:0] interval = DEBOUNCE_RESET;
  logic [TABLE_W-1:0]    codes_low = '0;
  logic [TABLE_W-1:0]    codes_high = '0;
  logic [LEVEL_W-1:0]    last_levels = '0;
  logic [TIME_W-1:0]     next_allowed = '0;

  out_item_t pending_presses[$];
  out_item_t fresh_presses[$];
  out_item_t check_want;
  logic [LEVEL_W-1:0] last_levels_sent = '0;
  logic [TIME_W-1:0]  scan_clock = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // directed snapshots; code of key k is 127 - 9k in this part
  dir_row_t dir_rows [20] = '{
    '{15'h0000, 32'd0,          CHK_QUIET,  '0},                  // first after reset
    '{15'h7FFF, 32'd0,          CHK_QUIET,  '0},
    '{15'h7FFE, 32'd0,          CHK_SINGLE, '{7'h7F, 4'd0, 1'b1}},
    '{15'h7FFF, 32'd1,          CHK_QUIET,  '0},
    '{15'h7FFE, 32'd4,          CHK_QUIET,  '0},                  // inside window
    '{15'h7FFF, 32'd4,          CHK_QUIET,  '0},
    '{15'h3FFF, 32'd5,          CHK_SINGLE, '{7'h01, 4'd14, 1'b1}},
    '{15'h7FFF, 32'd10,         CHK_QUIET,  '0},
    '{15'h0000, 32'd1000,       CHK_MODEL,  '0},                  // all keys at once
    '{15'h7FFF, 32'd1000,       CHK_QUIET,  '0},
    '{15'h0000, 32'd90,         CHK_MODEL,  '0},                  // window closes mid scan
    '{15'h7FFF, 32'd95,         CHK_QUIET,  '0},
    '{15'h5555, 32'hFFFF_FFFF,  CHK_MODEL,  '0},
    '{15'h7FFF, 32'hFFFF_FFFF,  CHK_QUIET,  '0},
    '{15'h2AAA, 32'hFFFF_FFFF,  CHK_MODEL,  '0},
    '{15'h2AAA, 32'd0,          CHK_QUIET,  '0},                  // keys held down
    '{15'h7FFF, 32'd0,          CHK_QUIET,  '0},
    '{15'h7FFB, 32'd0,          CHK_QUIET,  '0},
    '{15'h7FFF, 32'd169,        CHK_QUIET,  '0},
    '{15'h6FFF, 32'd170,        CHK_MODEL,  '0}                   // exactly at the bound
  };

  keypad_matrix_press_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each press transfer with the oldest expected press
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_presses.size() == 0) begin
        $display("%0t: unexpected press: code %0d key %0d final %0d", $time,
                 out_data.key_code, out_data.key_number, out_data.final_press);
        fail_count++;
      end else begin
        check_want = pending_presses.pop_front();
        if (out_data.key_code !== check_want.key_code) begin
          $display("%0t: key_code expected %0d actual %0d", $time,
                   check_want.key_code, out_data.key_code);
          fail_count++;
        end
        if (out_data.key_number !== check_want.key_number) begin
          $display("%0t: key_number expected %0d actual %0d", $time,
                   check_want.key_number, out_data.key_number);
          fail_count++;
        end
        if (out_data.final_press !== check_want.final_press) begin
          $display("%0t: final_press expected %0d actual %0d", $time,
                   check_want.final_press, out_data.final_press);
          fail_count++;
        end
      end
    end
  end

  // predictor: walk the keys in index order, fill fresh_presses
  task automatic scan_snapshot(input in_item_t snap);
    logic              cur;
    out_item_t         hit;
    int                k;
    fresh_presses.delete();
    for (k = 0; k < KEY_TOTAL; k++) begin
      cur = snap.key_levels[k];
      if (!cur && last_levels[k] && snap.now_ms >= next_allowed) begin
        hit.key_code    = (k < 8) ? codes_low[k*CODE_W +: CODE_W]
                                  : codes_high[(k-8)*CODE_W +: CODE_W];
        hit.key_number  = KEY_W'(k);
        hit.final_press = 1'b0;
        fresh_presses.push_back(hit);
        next_allowed = next_allowed + TIME_W'(interval);
      end
      last_levels[k] = cur;
    end
    if (fresh_presses.size() != 0) begin
      hit = fresh_presses.pop_back();
      hit.final_press = 1'b1;
      fresh_presses.push_back(hit);
    end
  endtask

  // one snapshot transfer, entered and left just after a falling edge
  task automatic send_snapshot(input in_item_t snap, input row_check_e chk,
                               input out_item_t single);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= snap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_snapshot(snap);
    if (chk == CHK_MODEL) begin
      foreach (fresh_presses[i]) pending_presses.push_back(fresh_presses[i]);
    end else if (chk == CHK_SINGLE) begin
      pending_presses.push_back(single);
    end
    last_levels_sent = snap.key_levels;
    @(negedge clk);
  endtask

  // hold the sender until every expected press has come out
  task automatic drain_presses(input int hold);
    in_valid <= 1'b0;
    while (pending_presses.size() != 0) @(posedge clk);
    repeat (hold) @(posedge clk);
    @(negedge clk);
  endtask

  // write all registers while idle, optionally poke the unused index
  task automatic load_settings(input logic [INTERVAL_W-1:0] ival,
                               input logic [TABLE_W-1:0] low,
                               input logic [TABLE_W-1:0] high,
                               input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= TABLE_W'(ival);
    @(negedge clk);
    cfg_index <= CFG_TABLE_LOW;
    cfg_data  <= low;
    @(negedge clk);
    cfg_index <= CFG_TABLE_HIGH;
    cfg_data  <= high;
    @(negedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= '1;
      @(negedge clk);
    end
    cfg_we     <= 1'b0;
    interval   = ival;
    codes_low  = low;
    codes_high = high;
  endtask

  // random snapshots: small changes in half of them, times mostly on a running clock
  task automatic run_random(input int count);
    in_item_t snap;
    int       pick;
    int       n;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) drain_presses(0);
      pick = $urandom_range(99);
      if (pick < 50)
        snap.key_levels = last_levels_sent ^
                          (LEVEL_W'($urandom) & LEVEL_W'($urandom) & LEVEL_W'($urandom));
      else if (pick < 72)
        snap.key_levels = LEVEL_W'($urandom);
      else if (pick < 87)
        snap.key_levels = '1;
      else if (pick < 95)
        snap.key_levels = '0;
      else
        snap.key_levels = last_levels_sent;
      pick = $urandom_range(99);
      if (pick < 80) begin
        scan_clock  = scan_clock + TIME_W'($urandom_range(2 * int'(interval) + 3, 0));
        snap.now_ms = scan_clock;
      end else if (pick < 92) begin
        snap.now_ms = $urandom;
      end else begin
        snap.now_ms = pick[0] ? '1 : '0;
      end
      send_snapshot(snap, CHK_MODEL, '0);
    end
  endtask

  initial begin
    in_item_t           snap;
    logic [TABLE_W-1:0] dir_low;
    logic [TABLE_W-1:0] dir_high;
    int                 k;

    dir_low  = '0;
    dir_high = '0;
    for (k = 0; k < 16; k++) begin
      if (k < 8) dir_low[k*CODE_W +: CODE_W] = CODE_W'(127 - 9 * k);
      else dir_high[(k-8)*CODE_W +: CODE_W] = CODE_W'(127 - 9 * k);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    send_idle_pct = 7;
    recv_idle_pct = 79;
    load_settings(16'd5, dir_low, dir_high, 1'b1);
    foreach (dir_rows[i]) begin
      snap.key_levels = dir_rows[i].levels;
      snap.now_ms     = dir_rows[i].now;
      send_snapshot(snap, dir_rows[i].chk, dir_rows[i].single);
    end
    scan_clock = 32'd200;

    // random part, sender rarely idle, receiver mostly stalled
    drain_presses(SCAN_HOLD);
    load_settings(INTERVAL_W'($urandom_range(50, 1)),
                  TABLE_W'({$urandom, $urandom}), TABLE_W'({$urandom, $urandom}), 1'b0);
    run_random(RANDOM_ITEMS);

    // zero interval, all-ones codes, sender mostly idle
    drain_presses(SCAN_HOLD);
    send_idle_pct = 79;
    recv_idle_pct = 7;
    load_settings('0, '1, '1, 1'b0);
    run_random(RANDOM_ITEMS);

    // widest interval, no idling
    drain_presses(SCAN_HOLD);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings('1, TABLE_W'({$urandom, $urandom}), TABLE_W'({$urandom, $urandom}), 1'b0);
    run_random(RANDOM_ITEMS);

    // release all keys, then random levels at arbitrary times
    drain_presses(SCAN_HOLD);
    load_settings('1, '0, '0, 1'b0);
    repeat (6) begin
      snap.key_levels = '1;
      snap.now_ms     = $urandom;
      send_snapshot(snap, CHK_MODEL, '0);
      snap.key_levels = LEVEL_W'($urandom);
      snap.now_ms     = $urandom_range(200000, 0);
      send_snapshot(snap, CHK_MODEL, '0);
    end

    drain_presses(40);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kmpd_pkg.sv
design/kmpd_scan.sv
design/kmpd_outreg.sv
design/keypad_matrix_press_detector.sv
tb/tb_top.sv
